@@ hw/rtl/conv3x3_valid_stream_assert.svh @@
// ----------------------------------------------------------------------------
// conv3x3_valid_stream assertion macros
// Shared concurrent assertion forms. Clock is clk, reset is rst_n.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_VALID_STREAM_ASSERT_SVH
`define CONV3X3_VALID_STREAM_ASSERT_SVH

// same-cycle implication
`define C3VS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define C3VS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/c3vs_pkg.sv @@
// ----------------------------------------------------------------------------
// c3vs_pkg
// Shared types and constants of the 3x3 valid-region convolution stream.
// ----------------------------------------------------------------------------
package c3vs_pkg;

  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 48;
  localparam int SIZE_BITS      = 10;
  localparam int COEF_BITS      = 16;
  localparam int KSIZE          = 3;
  localparam int KTAPS          = KSIZE * KSIZE;
  localparam int FRAC_BITS      = 8;
  localparam int OUT_BITS       = 20;
  localparam int OUT_TDATA_BITS = 24;
  localparam int OUT_MAX_VAL    = 524287;
  localparam int OUT_MIN_VAL    = -524288;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int QUEUE_CNT_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_TOP   = 3'd2,
    REG_KERNEL_MID   = 3'd3,
    REG_KERNEL_BOT   = 3'd4
  } cfg_reg_t;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  // tap k = 3*row + col, row 0 / col 0 is the oldest pixel
  typedef coef_t [KTAPS-1:0] kernel_t;

  typedef struct packed {
    logic row_done;
    logic frame_done;
  } marks_t;

endpackage

@@ hw/rtl/c3vs_front.sv @@
// ----------------------------------------------------------------------------
// c3vs_front
// Pixel intake: raster counters, line store, 3x3 window, window dispatch.
// ----------------------------------------------------------------------------
module c3vs_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      pix_valid,
  output logic                                      pix_ready,
  input  logic [PIXEL_BITS-1:0]                     pix_data,
  input  logic [c3vs_pkg::SIZE_BITS-1:0]            width_cfg,
  input  logic [c3vs_pkg::SIZE_BITS-1:0]            height_cfg,
  input  logic                                      q_full,
  output logic                                      q_push,
  output logic [c3vs_pkg::KTAPS*PIXEL_BITS-1:0]     q_window,
  output c3vs_pkg::marks_t                          q_marks
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SW0 = (CW > RW) ? CW + 1 : RW + 1;
  localparam int SW  = (SW0 > c3vs_pkg::SIZE_BITS) ? SW0 : c3vs_pkg::SIZE_BITS;
  localparam int K   = c3vs_pkg::KSIZE;

  logic [CW-1:0]           col_r;
  logic [RW-1:0]           row_r;
  logic [SW-1:0]           w_lim, h_lim, w_last, h_last;
  logic                    accept, row_end, frame_end, emit;

  // stage 1: pixel with its line store read
  logic                    s1_valid_r;
  logic [PIXEL_BITS-1:0]   s1_pix_r;
  logic [CW-1:0]           s1_addr_r;
  logic                    s1_emit_r;
  c3vs_pkg::marks_t        s1_marks_r;
  logic                    s1_adv;

  // one entry per column: {older row, newer row}
  logic [2*PIXEL_BITS-1:0] lines_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] rd_q_r, byp_data_r, line_word, wr_data;
  logic                    byp_r;
  logic [PIXEL_BITS-1:0]   top_px, mid_px;

  logic [PIXEL_BITS-1:0]   win_r [K][K];

  // size limits: zero reads as one, oversize as the maximum
  always_comb begin
    if (width_cfg == '0) begin
      w_lim = SW'(1);
    end else if (SW'(width_cfg) > SW'(MAX_WIDTH)) begin
      w_lim = SW'(MAX_WIDTH);
    end else begin
      w_lim = SW'(width_cfg);
    end
    if (height_cfg == '0) begin
      h_lim = SW'(1);
    end else if (SW'(height_cfg) > SW'(MAX_HEIGHT)) begin
      h_lim = SW'(MAX_HEIGHT);
    end else begin
      h_lim = SW'(height_cfg);
    end
    w_last = w_lim - SW'(1);
    h_last = h_lim - SW'(1);
  end

  assign row_end   = SW'(col_r) >= w_last;
  assign frame_end = SW'(row_r) >= h_last;
  assign emit      = (row_r >= RW'(2)) && (col_r >= CW'(2));

  assign s1_adv    = s1_valid_r && (!s1_emit_r || !q_full);
  assign pix_ready = !s1_valid_r || s1_adv;
  assign accept    = pix_valid && pix_ready;

  // write of the previous pixel may hit the column being read now
  assign line_word = byp_r ? byp_data_r : rd_q_r;
  assign top_px    = line_word[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid_px    = line_word[PIXEL_BITS-1:0];
  assign wr_data   = {mid_px, s1_pix_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (row_end) begin
          col_r <= '0;
          row_r <= frame_end ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r              <= pix_data;
      s1_addr_r             <= col_r;
      s1_emit_r             <= emit;
      s1_marks_r.row_done   <= row_end;
      s1_marks_r.frame_done <= row_end && frame_end;
      rd_q_r                <= lines_mem[col_r];
      byp_r                 <= s1_adv && (s1_addr_r == col_r);
      byp_data_r            <= wr_data;
    end
    if (s1_adv) begin
      lines_mem[s1_addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < K; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= top_px;
      win_r[1][2] <= mid_px;
      win_r[2][2] <= s1_pix_r;
    end
  end

  // dispatch the window as it stands after this pixel's shift
  always_comb begin
    for (int i = 0; i < K; i++) begin
      q_window[(K*i+0)*PIXEL_BITS +: PIXEL_BITS] = win_r[i][1];
      q_window[(K*i+1)*PIXEL_BITS +: PIXEL_BITS] = win_r[i][2];
    end
    q_window[(K*0+2)*PIXEL_BITS +: PIXEL_BITS] = top_px;
    q_window[(K*1+2)*PIXEL_BITS +: PIXEL_BITS] = mid_px;
    q_window[(K*2+2)*PIXEL_BITS +: PIXEL_BITS] = s1_pix_r;
  end

  assign q_push  = s1_adv && s1_emit_r;
  assign q_marks = s1_marks_r;

endmodule

@@ hw/rtl/c3vs_queue.sv @@
// ----------------------------------------------------------------------------
// c3vs_queue
// Short FIFO of dispatched windows between intake and arithmetic.
// ----------------------------------------------------------------------------
module c3vs_queue #(
  parameter int WIDTH = 74
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

`include "conv3x3_valid_stream_assert.svh"

  localparam int PB = c3vs_pkg::QUEUE_PTR_BITS;
  localparam int CB = c3vs_pkg::QUEUE_CNT_BITS;

  logic [WIDTH-1:0] slot_r [c3vs_pkg::QUEUE_DEPTH];
  logic [PB-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CB-1:0]    cnt_r;

  assign full     = cnt_r == CB'(c3vs_pkg::QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PB'(c3vs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PB'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PB'(c3vs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PB'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CB'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `C3VS_ASSERT_NOW(a_no_push_full, full, !push, "window pushed into a full queue")
  `C3VS_ASSERT_NOW(a_no_pop_empty, empty, !pop, "window popped from an empty queue")
  `C3VS_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + CB'(1), "queue count did not rise")

endmodule

@@ hw/rtl/c3vs_back.sv @@
// ----------------------------------------------------------------------------
// c3vs_back
// Multiply-accumulate pipeline, truncation, saturation and output register.
// ----------------------------------------------------------------------------
module c3vs_back #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  output logic                                  q_pop,
  input  logic [c3vs_pkg::KTAPS*PIXEL_BITS-1:0] q_window,
  input  c3vs_pkg::marks_t                      q_marks,
  input  c3vs_pkg::kernel_t                     kernel,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic [c3vs_pkg::OUT_BITS-1:0]         res_value,
  output c3vs_pkg::marks_t                      res_marks
);

`include "conv3x3_valid_stream_assert.svh"

  localparam int NT  = c3vs_pkg::KTAPS;
  localparam int PW  = PIXEL_BITS + 1 + c3vs_pkg::COEF_BITS;
  localparam int BW  = PW + 2;
  localparam int CWD = PW + 4;
  localparam int QN  = CWD - c3vs_pkg::FRAC_BITS;
  localparam int QW  = (QN > c3vs_pkg::OUT_BITS) ? QN : c3vs_pkg::OUT_BITS;
  localparam logic signed [QW-1:0] Q_MAX = QW'(c3vs_pkg::OUT_MAX_VAL);
  localparam logic signed [QW-1:0] Q_MIN = QW'(c3vs_pkg::OUT_MIN_VAL);

  logic                   stall, adv;
  logic                   va_r, vb_r, vc_r, vd_r;
  c3vs_pkg::marks_t       ma_r, mb_r, mc_r, md_r;
  logic signed [PW-1:0]   prod_nxt [NT];
  logic signed [PW-1:0]   prod_r   [NT];
  logic signed [BW-1:0]   part_nxt [c3vs_pkg::KSIZE];
  logic signed [BW-1:0]   part_r   [c3vs_pkg::KSIZE];
  logic signed [CWD-1:0]  sum_nxt, sum_r;
  logic signed [QN-1:0]   quo;
  logic signed [QW-1:0]   quo_ext;
  logic [c3vs_pkg::OUT_BITS-1:0] val_nxt, val_r;

  assign stall = vd_r && !res_ready;
  assign adv   = !stall;
  assign q_pop = adv && q_valid;

  always_comb begin
    for (int k = 0; k < NT; k++) begin
      prod_nxt[k] = $signed({1'b0, q_window[k*PIXEL_BITS +: PIXEL_BITS]})
                    * $signed(kernel[k]);
    end
    for (int i = 0; i < c3vs_pkg::KSIZE; i++) begin
      part_nxt[i] = BW'(prod_r[3*i]) + BW'(prod_r[3*i+1]) + BW'(prod_r[3*i+2]);
    end
    sum_nxt = CWD'(part_r[0]) + CWD'(part_r[1]) + CWD'(part_r[2]);
  end

  // divide by 256 rounding toward zero, then clamp to 20 bits
  always_comb begin
    quo = QN'(sum_r >>> c3vs_pkg::FRAC_BITS);
    if (sum_r[CWD-1] && (sum_r[c3vs_pkg::FRAC_BITS-1:0] != '0)) begin
      quo = quo + QN'(1);
    end
    quo_ext = QW'(quo);
    if (quo_ext > Q_MAX) begin
      val_nxt = Q_MAX[c3vs_pkg::OUT_BITS-1:0];
    end else if (quo_ext < Q_MIN) begin
      val_nxt = Q_MIN[c3vs_pkg::OUT_BITS-1:0];
    end else begin
      val_nxt = quo_ext[c3vs_pkg::OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (adv) begin
      va_r <= q_pop;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      ma_r   <= q_marks;
      part_r <= part_nxt;
      mb_r   <= ma_r;
      sum_r  <= sum_nxt;
      mc_r   <= mb_r;
      val_r  <= val_nxt;
      md_r   <= mc_r;
    end
  end

  assign res_valid = vd_r;
  assign res_value = val_r;
  assign res_marks = md_r;

  `C3VS_ASSERT_NEXT(a_pop_lands, q_pop, va_r, "popped window missing from stage A")
  `C3VS_ASSERT_NEXT(a_stall_holds, stall, (vc_r == $past(vc_r)) && (vb_r == $past(vb_r)), "pipeline moved during stall")
  `C3VS_ASSERT_NEXT(a_drain, vc_r && adv, vd_r, "stage C result lost")

endmodule

@@ hw/rtl/conv3x3_valid_stream.sv @@
// ----------------------------------------------------------------------------
// conv3x3_valid_stream
// Streaming 3x3 convolution over the valid region of a raster image.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on in_, one per clock unless the queue is full.
// A pixel is taken while earlier windows are still in the multiply pipeline.
// While a finished result waits on the out_ side, pixels are still taken until
// the four-deep window queue fills. For every position with row >= 2 and
// column >= 2 one result leaves: the sum of nine pixel times signed Q8.8
// coefficient products, divided by 256 toward zero and clamped to 20 bits.
// out_tlast marks the last result of an output row, out_tuser the last of the
// frame. The throughput figure is set by the line store, a single memory of
// MAX_WIDTH words with one read and one write port per clock: each pixel reads
// its column once and writes it back once. out_tvalid is registered, and a
// pixel's result passes the line-store read register, a slot in the four-deep
// queue and four arithmetic stages before it leaves. The line store is not
// cleared after reset and needs no clearing pass; entries not yet written
// are read only in the first two rows of a frame, and those values never
// reach a result. Sizes and coefficients are to be written by the user through
// the cfg_ port only while no item is in flight, unchecked by the block itself;
// width or height 0 act as 1, sizes above the maximum act as the maximum, and
// with fewer than three rows or columns pixels are consumed without results.
// ----------------------------------------------------------------------------
module conv3x3_valid_stream #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 8,
  localparam int IN_TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // pixel input
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [IN_TDATA_BITS-1:0]               in_tdata,   // [PIXEL_BITS-1:0] pixel_value
  // result output
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [c3vs_pkg::OUT_TDATA_BITS-1:0]    out_tdata,  // [19:0] filtered_value
  output logic                                   out_tlast,  // row_done
  output logic [0:0]                             out_tuser,  // [0] frame_done
  // register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [c3vs_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [c3vs_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int WIN_BITS = c3vs_pkg::KTAPS * PIXEL_BITS;
  localparam int Q_BITS   = WIN_BITS + $bits(c3vs_pkg::marks_t);

  // configuration registers
  logic [c3vs_pkg::SIZE_BITS-1:0]     width_r, height_r;
  logic [c3vs_pkg::CFG_DATA_BITS-1:0] krow_r [c3vs_pkg::KSIZE];
  c3vs_pkg::kernel_t                  kernel;

  // front to queue
  logic                  f_push;
  logic [WIN_BITS-1:0]   f_window;
  c3vs_pkg::marks_t      f_marks;
  logic                  q_full, q_empty, q_pop;
  logic [Q_BITS-1:0]     q_data;
  c3vs_pkg::marks_t      q_marks;

  // back to port
  logic [c3vs_pkg::OUT_BITS-1:0] res_value;
  c3vs_pkg::marks_t              res_marks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= c3vs_pkg::SIZE_BITS'(512);
      height_r <= c3vs_pkg::SIZE_BITS'(512);
      for (int i = 0; i < c3vs_pkg::KSIZE; i++) begin
        krow_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (c3vs_pkg::cfg_reg_t'(cfg_index))
        c3vs_pkg::REG_IMAGE_WIDTH:  width_r   <= cfg_data[c3vs_pkg::SIZE_BITS-1:0];
        c3vs_pkg::REG_IMAGE_HEIGHT: height_r  <= cfg_data[c3vs_pkg::SIZE_BITS-1:0];
        c3vs_pkg::REG_KERNEL_TOP:   krow_r[0] <= cfg_data;
        c3vs_pkg::REG_KERNEL_MID:   krow_r[1] <= cfg_data;
        c3vs_pkg::REG_KERNEL_BOT:   krow_r[2] <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // unpack coefficients, column 0 in the low 16 bits of each row
  always_comb begin
    for (int r = 0; r < c3vs_pkg::KSIZE; r++) begin
      for (int c = 0; c < c3vs_pkg::KSIZE; c++) begin
        kernel[c3vs_pkg::KSIZE*r + c] =
          krow_r[r][c3vs_pkg::COEF_BITS*c +: c3vs_pkg::COEF_BITS];
      end
    end
  end

  c3vs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (in_tvalid),
    .pix_ready  (in_tready),
    .pix_data   (in_tdata[PIXEL_BITS-1:0]),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .q_full     (q_full),
    .q_push     (f_push),
    .q_window   (f_window),
    .q_marks    (f_marks)
  );

  c3vs_queue #(
    .WIDTH (Q_BITS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_marks, f_window}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign q_marks = q_data[Q_BITS-1:WIN_BITS];

  c3vs_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .q_pop     (q_pop),
    .q_window  (q_data[WIN_BITS-1:0]),
    .q_marks   (q_marks),
    .kernel    (kernel),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_value (res_value),
    .res_marks (res_marks)
  );

  assign out_tdata = {{(c3vs_pkg::OUT_TDATA_BITS - c3vs_pkg::OUT_BITS){1'b0}}, res_value};
  assign out_tlast = res_marks.row_done;
  assign out_tuser = res_marks.frame_done;

endmodule

@@ tb/tb_conv3x3_valid_stream.sv @@
// ----------------------------------------------------------------------------
// tb_conv3x3_valid_stream
// Self-checking bench for the streaming 3x3 valid-region convolution.
// ----------------------------------------------------------------------------
// Pixels go in through the in_ stream and filtered results come back on the
// out_ stream. A behavioral copy of the line stores, the 3x3 window and the
// raster counters predicts each result not typed in by hand; all results are
// queued and compared field by field (value, row end, frame end) with the
// block's output. A short table of hand-picked frames comes first, then size
// corners and a mid-frame shrink, then frames of random size, content and
// coefficients, with random gaps on input and random back-pressure on output.
// Sizes and coefficients are rewritten only once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_conv3x3_valid_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import c3vs_pkg::*;

  localparam int LINE_MAX      = 512;   // MAX_WIDTH of the block
  localparam int FRAME_MAX     = 512;   // MAX_HEIGHT of the block
  localparam int SETTLE_CYCLES = 16;    // drain margin for the window queue and the arithmetic pipeline
  localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake
  localparam int RANDOM_ITEMS  = 250;

  // one filtered result as seen on the out_ stream
  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    marks_t                     marks;
  } conv_result_t;

  typedef enum bit {STEP_CFG, STEP_PIXEL} step_kind_t;

  // directed table row: a register write or one pixel, optionally with the
  // result typed in by hand
  typedef struct packed {
    step_kind_t                 kind;
    cfg_reg_t                   reg_sel;
    logic [CFG_DATA_BITS-1:0]   data;
    bit                         typed;
    conv_result_t               want;
  } stim_row_t;

  localparam logic [47:0] KERN_ONE     = 48'h0100_0100_0100;  // 1.0 in every column
  localparam logic [47:0] KERN_MOST_NEG = 48'h8000_8000_8000; // -128.0
  localparam logic [47:0] KERN_NEG_LSB = 48'hFFFF_FFFF_FFFF;  // -1/256
  localparam conv_result_t NO_WANT     = '0;

  // Pixel rows carry REG_IMAGE_WIDTH as a filler selector; it is not used.
  localparam stim_row_t DIRECTED_STEPS [36] = '{
    // 3x3 frame, all-ones kernel, full-scale pixels: one result, 9 * 255
    '{STEP_CFG,   REG_IMAGE_WIDTH,  48'd3,    1'b0, NO_WANT},
    '{STEP_CFG,   REG_IMAGE_HEIGHT, 48'd3,    1'b0, NO_WANT},
    '{STEP_CFG,   REG_KERNEL_TOP,   KERN_ONE, 1'b0, NO_WANT},
    '{STEP_CFG,   REG_KERNEL_MID,   KERN_ONE, 1'b0, NO_WANT},
    '{STEP_CFG,   REG_KERNEL_BOT,   KERN_ONE, 1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b1, '{20'sd2295, '{1'b1, 1'b1}}},
    // 3x4 frame, most negative coefficients on top and middle rows and
    // -1/256 on the bottom row: both results need truncation toward zero
    '{STEP_CFG,   REG_KERNEL_TOP,   KERN_MOST_NEG, 1'b0, NO_WANT},
    '{STEP_CFG,   REG_KERNEL_MID,   KERN_MOST_NEG, 1'b0, NO_WANT},
    '{STEP_CFG,   REG_KERNEL_BOT,   KERN_NEG_LSB,  1'b0, NO_WANT},
    '{STEP_CFG,   REG_IMAGE_HEIGHT, 48'd4,    1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd0,    1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd128,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd0,    1'b0, NO_WANT},
    // 2x2 frame: pixels are consumed, nothing comes out
    '{STEP_CFG,   REG_IMAGE_WIDTH,  48'd2,    1'b0, NO_WANT},
    '{STEP_CFG,   REG_IMAGE_HEIGHT, 48'd2,    1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd255,  1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd0,    1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd1,    1'b0, NO_WANT},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  48'd254,  1'b0, NO_WANT}
  };

  // size corners: clamped maxima (one full-width row, one full-height
  // column), zero sizes, shapes too small for a window
  localparam int CORNER_W [6]      = '{1023, 0,    0, 2, 9, 1};
  localparam int CORNER_H [6]      = '{1,    1023, 0, 9, 2, 1};
  localparam int CORNER_FRAMES [6] = '{1,    1,    4, 2, 2, 3};

  logic                          clk;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata   = '0;   // [7:0] pixel_value
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0]     out_tdata;         // [19:0] filtered_value
  logic                          out_tlast;         // row_done
  logic [0:0]                    out_tuser;         // [0] frame_done
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data   = '0;

  // expected results, oldest first
  conv_result_t pending_results [$];

  // predictor state: registers, line stores, window, raster position
  logic [SIZE_BITS-1:0] width_reg;
  logic [SIZE_BITS-1:0] height_reg;
  kernel_t              kern_taps;
  logic [7:0]           line_older [LINE_MAX];
  logic [7:0]           line_newer [LINE_MAX];
  logic [7:0]           window_px [KSIZE][KSIZE];
  int unsigned          col_count;
  int unsigned          row_count;

  bit          steady_flow;   // no gaps and no stalls while set
  bit          burst_open;    // pixels sent since the block last went quiet
  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned reg_writes;
  int unsigned size_settings;
  int unsigned quiet_cycles = 0;

  conv3x3_valid_stream #(
    .MAX_WIDTH  (LINE_MAX),
    .MAX_HEIGHT (FRAME_MAX),
    .PIXEL_BITS (8)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_size(logic [SIZE_BITS-1:0] v, int unsigned cap);
    if (v == 0) return 1;
    if (32'(v) > cap) return cap;
    return 32'(v);
  endfunction

  task automatic clear_raster_model();
    width_reg  = 10'd512;
    height_reg = 10'd512;
    kern_taps  = '0;
    foreach (line_older[i]) begin
      line_older[i] = '0;
      line_newer[i] = '0;
    end
    foreach (window_px[i, j]) window_px[i][j] = '0;
    col_count = 0;
    row_count = 0;
  endtask

  task automatic apply_reg(cfg_reg_t sel, logic [CFG_DATA_BITS-1:0] val);
    int k;
    case (sel) inside
      REG_IMAGE_WIDTH:  width_reg  = val[SIZE_BITS-1:0];
      REG_IMAGE_HEIGHT: height_reg = val[SIZE_BITS-1:0];
      REG_KERNEL_TOP, REG_KERNEL_MID, REG_KERNEL_BOT: begin
        k = int'(sel) - int'(REG_KERNEL_TOP);
        for (int c = 0; c < KSIZE; c++) kern_taps[KSIZE*k + c] = val[COEF_BITS*c +: COEF_BITS];
      end
      default: ;
    endcase
  endtask

  // Takes one pixel, moves the raster along and tells whether a window fits.
  task automatic advance_raster(input logic [7:0] pix, output bit emits,
                                output conv_result_t res);
    int unsigned w, h, c, r;
    logic [7:0]  top, mid;
    longint      acc, q;
    bit          row_end, frame_end;
    w = eff_size(width_reg, LINE_MAX);
    h = eff_size(height_reg, FRAME_MAX);
    c = col_count;
    r = row_count;
    row_end   = (c >= w - 1);
    frame_end = (r >= h - 1);
    top = '0;
    mid = '0;
    if (c < LINE_MAX) begin
      top = line_older[c];
      mid = line_newer[c];
      line_older[c] = mid;
      line_newer[c] = pix;
    end
    for (int i = 0; i < KSIZE; i++) begin
      window_px[i][0] = window_px[i][1];
      window_px[i][1] = window_px[i][2];
    end
    window_px[0][2] = top;
    window_px[1][2] = mid;
    window_px[2][2] = pix;

    emits = (r >= 2) && (c >= 2);
    res   = '0;
    if (emits) begin
      acc = 0;
      for (int i = 0; i < KSIZE; i++)
        for (int j = 0; j < KSIZE; j++)
          acc += longint'(kern_taps[KSIZE*i + j]) * longint'(window_px[i][j]);
      q = acc / (longint'(1) << FRAC_BITS);  // signed divide truncates toward zero
      if (q > OUT_MAX_VAL) q = OUT_MAX_VAL;
      if (q < OUT_MIN_VAL) q = OUT_MIN_VAL;
      res.value            = q[OUT_BITS-1:0];
      res.marks.row_done   = row_end;
      res.marks.frame_done = row_end && frame_end;
    end

    if (row_end) begin
      col_count = 0;
      row_count = frame_end ? 0 : r + 1;
    end else begin
      col_count = c + 1;
    end
  endtask

  // ------------------------------------------------------------- random draws

  // mostly the shortest pauses, some a little longer, rarely a long one
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(2, 4);
    if (r < 98) return $urandom_range(5, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned sender_gap();
    if (steady_flow || $urandom_range(0, 2) != 0) return 0;
    return pick_pause();
  endfunction

  function automatic logic [7:0] draw_pixel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] draw_kernel_row();
    logic [CFG_DATA_BITS-1:0] row;
    case ($urandom_range(0, 5))
      0: row = 48'h7FFF_7FFF_7FFF;
      1: row = KERN_MOST_NEG;
      2: for (int c = 0; c < KSIZE; c++)
           row[COEF_BITS*c +: COEF_BITS] = 16'($urandom_range(0, 1023)) - 16'd512;
      default: row = {16'($urandom), 32'($urandom)};
    endcase
    return row;
  endfunction

  // ------------------------------------------------------------------ drivers

  // Drops in_tvalid, waits for every expected result, then lets the
  // result-less pixels still in the pipe drain out.
  task automatic wait_quiet();
    if (in_tvalid) @(negedge clk) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_open = 1'b0;
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_BITS-1:0] val);
    if (burst_open) wait_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(sel, val);
    reg_writes++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // in_tvalid stays high into the next item when there is no gap
  task automatic send_pixel(logic [7:0] pix, bit typed, conv_result_t typed_want);
    int unsigned  gap;
    bit           emits;
    conv_result_t predicted;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_raster(pix, emits, predicted);
    if (typed) pending_results.push_back(typed_want);
    else if (emits) pending_results.push_back(predicted);
    pixels_sent++;
    burst_open = 1'b1;
  endtask

  // random pixels until the raster is back at the top-left corner
  task automatic finish_frame();
    do send_pixel(draw_pixel(), 1'b0, NO_WANT);
    while (!(row_count == 0 && col_count == 0));
  endtask

  // New size, some new kernel rows, then whole frames.
  task automatic run_setting(int w, int h, int frames);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
    for (int k = 0; k < KSIZE; k++)
      if ($urandom_range(0, 1) == 0)
        write_reg(cfg_reg_t'(int'(REG_KERNEL_TOP) + k), draw_kernel_row());
    steady_flow = ($urandom_range(0, 4) == 0);
    size_settings++;
    repeat (frames) finish_frame();
  endtask

  // ------------------------------------------------------------ result side

  // ready mostly high, with random stalls; none at all while steady_flow
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 3) == 0) stall = pick_pause();
      end
    end
  end

  task automatic report_field(string name, longint want, longint got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    conv_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.value            = out_tdata[OUT_BITS-1:0];
      got.marks.row_done   = out_tlast;
      got.marks.frame_done = out_tuser[0];
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got value %0d row %0b frame %0b",
                 $time, got.value, got.marks.row_done, got.marks.frame_done);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value)
          report_field("filtered_value", want.value, got.value);
        if (got.marks.row_done !== want.marks.row_done)
          report_field("row_done", want.marks.row_done, got.marks.row_done);
        if (got.marks.frame_done !== want.marks.frame_done)
          report_field("frame_done", want.marks.frame_done, got.marks.frame_done);
      end
    end
  end

  // Ends the run if no channel moves anything for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------- main flow

  initial begin : stimulus
    int unsigned random_start;
    steady_flow   = 1'b0;
    burst_open    = 1'b0;
    mismatches    = 0;
    pixels_sent   = 0;
    results_seen  = 0;
    reg_writes    = 0;
    size_settings = 0;
    clear_raster_model();

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // hand-picked frames
    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].kind == STEP_CFG)
        write_reg(DIRECTED_STEPS[i].reg_sel, DIRECTED_STEPS[i].data);
      else
        send_pixel(DIRECTED_STEPS[i].data[7:0], DIRECTED_STEPS[i].typed,
                   DIRECTED_STEPS[i].want);
    end

    // size corners; the max-height frame with width 1 checks that the row
    // counter wraps correctly, seen through the frames that follow
    foreach (CORNER_W[i]) run_setting(CORNER_W[i], CORNER_H[i], CORNER_FRAMES[i]);

    // Shrink mid-frame: stop at row 3 column 4 of an 8x6 frame, then drop
    // to 3x2. The column and row counters are already past the new ends, so
    // the next pixel closes both row and frame.
    run_setting(8, 6, 0);
    repeat (3 * 8 + 4) send_pixel(draw_pixel(), 1'b0, NO_WANT);
    write_reg(REG_IMAGE_WIDTH, 48'd3);
    write_reg(REG_IMAGE_HEIGHT, 48'd2);
    finish_frame();

    // random sizes, mostly small frames, now and then a wide one
    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        run_setting($urandom_range(21, 64), $urandom_range(3, 5), 1);
      else
        run_setting($urandom_range(3, 20), $urandom_range(3, 8), $urandom_range(1, 3));
    end

    wait_quiet();

    $display("Covered %0d pixels, %0d filtered results, %0d size settings",
             pixels_sent, results_seen, size_settings);
    $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ conv3x3_valid_stream.f @@
+incdir+hw/rtl
hw/rtl/c3vs_pkg.sv
hw/rtl/c3vs_front.sv
hw/rtl/c3vs_queue.sv
hw/rtl/c3vs_back.sv
hw/rtl/conv3x3_valid_stream.sv
tb/tb_conv3x3_valid_stream.sv
